@@ src/av_pes_deframer_checker_unit_assert.svh @@
// assertion macros for the av pes deframer checker unit
// expects clk and arst_n in the scope of each use
`ifndef AV_PES_DEFRAMER_CHECKER_UNIT_ASSERT_SVH
`define AV_PES_DEFRAMER_CHECKER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// condition implies consequence in the same cycle
`define AVPES_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("avpes assertion failed");

// condition implies consequence in the following cycle
`define AVPES_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("avpes assertion failed");

`else

`define AVPES_ASSERT_NOW(label, ante, cons)
`define AVPES_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ src/avpes_pkg.sv @@
// shared types and constants of the av pes deframer checker
// no dependencies

package avpes_pkg;

	// sync sequence bytes
	localparam logic [7:0] SYNC_A = 8'hAA;
	localparam logic [7:0] SYNC_Z = 8'h00;

	// av marker, swapped bytes 0 and 1 ('A','V'), raw order 'V','A'
	localparam logic [7:0] MARK_A = 8'h41;
	localparam logic [7:0] MARK_V = 8'h56;

	// stream type codes from the frame type byte
	localparam logic [7:0] TYPE_CODE_VIDEO = 8'h01;
	localparam logic [7:0] TYPE_CODE_AUDIO = 8'h02;

	// frame layout: 8 header bytes, payload, 4 trailer bytes
	localparam int unsigned CNT_W          = 17;
	localparam int unsigned HDR_LEN        = 8;
	localparam int unsigned TRAILER_LEN    = 4;
	localparam int unsigned MIN_FRAME_LEN  = 16;
	localparam int unsigned MIN_PAYLOAD    = MIN_FRAME_LEN - HDR_LEN - TRAILER_LEN;
	localparam int unsigned LAST_OFS       = HDR_LEN + TRAILER_LEN - 1;

	// header byte positions
	localparam logic [CNT_W-1:0] IDX_MARK  = CNT_W'(1);
	localparam logic [CNT_W-1:0] IDX_TYPE  = CNT_W'(3);
	localparam logic [CNT_W-1:0] IDX_LEN_L = CNT_W'(6);
	localparam logic [CNT_W-1:0] IDX_LEN_H = CNT_W'(7);
	localparam logic [CNT_W-1:0] IDX_BODY  = CNT_W'(HDR_LEN);

	// register reset value
	localparam logic [15:0] MAX_PAYLOAD_RST = 16'd4096;

	// output queue depth in result pairs (power of two, at least 2)
	localparam int unsigned OUTQ_PAIRS = 2;

	typedef enum logic [2:0] {
		HUNT_A0  = 3'd0,
		HUNT_A1  = 3'd1,
		HUNT_Z   = 3'd2,
		HUNT_A2  = 3'd3,
		IN_FRAME = 3'd4
	} hunt_e_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_SHORT     = 3'd1,
		ST_CHECKSUM  = 3'd2,
		ST_LONG      = 3'd3,
		ST_NO_MARKER = 3'd4,
		ST_BAD_TYPE  = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		STYPE_VIDEO   = 2'd0,
		STYPE_AUDIO   = 2'd1,
		STYPE_UNKNOWN = 2'd2
	} stype_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		status_t    status;
		stype_t     stype;
	} result_t;

	// two results caused by one byte, res_a leaves first
	typedef struct packed {
		result_t res_a;
		result_t res_b;
	} pair_t;

endpackage

@@ src/av_pes_deframer_checker_unit.sv @@
// av pes deframer checker: input register, frame parser, result queue
// a byte's results pass through the input register and the result queue before they are offered
// throughput: one input byte per cycle while the queue has room; results leave one per cycle unless out_stall,
// two per odd byte or unpaired last byte; the output queue holds PAIR_DEPTH result pairs;
// a full queue stalls a byte that must push a pair; reset clears sync hunt, frame state and queue;
// max_payload returns to 4096; depends on avpes_pkg, avpes_parse, avpes_outq

module av_pes_deframer_checker_unit import avpes_pkg::*; #(
	parameter int unsigned PAIR_DEPTH = OUTQ_PAIRS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        frame_last,
	output logic [2:0]  frame_status,
	output logic [1:0]  stream_type
);

	logic [15:0] max_payload_q;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        push_req, full, step, in_xfer;
	pair_t       pair;
	result_t     out_res;

	// input register advances unless its byte needs queue space that is missing
	assign step     = valid_s1 && !(push_req && full);
	assign in_stall = valid_s1 && !step;
	assign in_xfer  = in_valid && !in_stall;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= MAX_PAYLOAD_RST;
		end else if (cfg_we) begin
			max_payload_q <= cfg_wdata;
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			byte_s1 <= in_byte;
		end
	end

	avpes_parse u_parse (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_s1     (byte_s1),
		.step        (step),
		.max_payload (max_payload_q),
		.push_req    (push_req),
		.pair        (pair)
	);

	avpes_outq #(
		.PAIR_DEPTH (PAIR_DEPTH)
	) u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (step && push_req),
		.push_pair (pair),
		.full      (full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (out_res)
	);

	// result fields
	assign out_byte     = out_res.data;
	assign frame_last   = out_res.last;
	assign frame_status = out_res.status;
	assign stream_type  = out_res.stype;

endmodule

@@ src/avpes_parse.sv @@
// sync hunt, frame parse, checksum and status for one registered byte
// depends on avpes_pkg and the assertion macro header
`include "av_pes_deframer_checker_unit_assert.svh"

module avpes_parse import avpes_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  byte_s1,
	input  logic        step,
	input  logic [15:0] max_payload,
	output logic        push_req,
	output pair_t       pair
);

	hunt_e_t          hunt_q, hunt_nx;
	logic [CNT_W-1:0] byte_count_q;
	logic [15:0]      payload_length_q;
	logic [7:0]       even_xor_q, odd_xor_q;
	logic [7:0]       held_byte_q;
	logic             marker_ok_q;
	logic [7:0]       type_byte_q;

	logic             in_frame, frame_start, odd_idx, last;
	logic [7:0]       even_xor_nx, odd_xor_nx;
	status_t          status;
	stype_t           stype;

	// datapath for the current frame byte
	always_comb begin
		in_frame    = (hunt_q == IN_FRAME);
		frame_start = (hunt_q == HUNT_A2) && (byte_s1 == SYNC_A);
		odd_idx     = byte_count_q[0];
		even_xor_nx = odd_idx ? even_xor_q : (even_xor_q ^ byte_s1);
		odd_xor_nx  = odd_idx ? (odd_xor_q ^ byte_s1) : odd_xor_q;
		last        = (byte_count_q >= IDX_BODY) &&
			(byte_count_q == ({1'b0, payload_length_q} + CNT_W'(LAST_OFS)));

		// status in priority order
		priority if (payload_length_q < 16'(MIN_PAYLOAD)) begin
			status = ST_SHORT;
		end else if ((even_xor_nx | odd_xor_nx) != 8'h00) begin
			status = ST_CHECKSUM;
		end else if (payload_length_q > max_payload) begin
			status = ST_LONG;
		end else if (!marker_ok_q) begin
			status = ST_NO_MARKER;
		end else if ((type_byte_q != TYPE_CODE_VIDEO) && (type_byte_q != TYPE_CODE_AUDIO)) begin
			status = ST_BAD_TYPE;
		end else begin
			status = ST_OK;
		end

		if (type_byte_q == TYPE_CODE_VIDEO) begin
			stype = STYPE_VIDEO;
		end else if (type_byte_q == TYPE_CODE_AUDIO) begin
			stype = STYPE_AUDIO;
		end else begin
			stype = STYPE_UNKNOWN;
		end
	end

	// next hunt state
	always_comb begin
		unique case (hunt_q)
			HUNT_A0:  hunt_nx = (byte_s1 == SYNC_A) ? HUNT_A1 : HUNT_A0;
			HUNT_A1:  hunt_nx = (byte_s1 == SYNC_A) ? HUNT_Z : HUNT_A0;
			HUNT_Z:   hunt_nx = (byte_s1 == SYNC_Z) ? HUNT_A2 : HUNT_A0;
			HUNT_A2:  hunt_nx = (byte_s1 == SYNC_A) ? IN_FRAME : HUNT_A0;
			IN_FRAME: hunt_nx = last ? HUNT_A0 : IN_FRAME;
			default:  hunt_nx = (byte_s1 == SYNC_A) ? HUNT_A1 : HUNT_A0;
		endcase
	end

	// result pair: odd byte pairs with the held byte, unpaired last gets a zero
	always_comb begin
		push_req           = in_frame && (odd_idx || last);
		pair.res_a.data    = odd_idx ? byte_s1 : 8'h00;
		pair.res_a.last    = 1'b0;
		pair.res_a.status  = ST_OK;
		pair.res_a.stype   = STYPE_VIDEO;
		pair.res_b.data    = odd_idx ? held_byte_q : byte_s1;
		pair.res_b.last    = last;
		pair.res_b.status  = last ? status : ST_OK;
		pair.res_b.stype   = last ? stype : STYPE_VIDEO;
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hunt_q           <= HUNT_A0;
			byte_count_q     <= '0;
			payload_length_q <= '0;
			even_xor_q       <= '0;
			odd_xor_q        <= '0;
			held_byte_q      <= '0;
			marker_ok_q      <= 1'b0;
			type_byte_q      <= '0;
		end else if (step) begin
			hunt_q <= hunt_nx;
			if (frame_start) begin
				byte_count_q     <= '0;
				payload_length_q <= '0;
				even_xor_q       <= '0;
				odd_xor_q        <= '0;
				held_byte_q      <= '0;
				marker_ok_q      <= 1'b0;
				type_byte_q      <= '0;
			end else if (in_frame) begin
				byte_count_q <= byte_count_q + CNT_W'(1);
				even_xor_q   <= even_xor_nx;
				odd_xor_q    <= odd_xor_nx;
				if (!odd_idx) begin
					held_byte_q <= byte_s1;
				end
				if (byte_count_q == IDX_MARK) begin
					marker_ok_q <= (held_byte_q == MARK_V) && (byte_s1 == MARK_A);
				end
				if (byte_count_q == IDX_TYPE) begin
					type_byte_q <= byte_s1;
				end
				if (byte_count_q == IDX_LEN_L) begin
					payload_length_q[7:0] <= byte_s1;
				end
				if (byte_count_q == IDX_LEN_H) begin
					payload_length_q[15:8] <= byte_s1;
				end
			end
		end
	end

	// a frame's last byte sends the block back to hunting
	`AVPES_ASSERT_NEXT(a_last_rehunt, step && push_req && pair.res_b.last, hunt_q == HUNT_A0)
	// the byte index never runs past the frame end
	`AVPES_ASSERT_NOW(a_idx_bound, (hunt_q == IN_FRAME) && (byte_count_q >= IDX_BODY),
		byte_count_q <= ({1'b0, payload_length_q} + CNT_W'(LAST_OFS)))

endmodule

@@ src/avpes_outq.sv @@
// output queue of result pairs, delivered one result per transfer
// depends on avpes_pkg and the assertion macro header
`include "av_pes_deframer_checker_unit_assert.svh"

module avpes_outq import avpes_pkg::*; #(
	parameter int unsigned PAIR_DEPTH = OUTQ_PAIRS
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  pair_t   push_pair,
	output logic    full,
	output logic    out_valid,
	input  logic    out_stall,
	output result_t out_res
);

	localparam int unsigned PTR_W = $clog2(PAIR_DEPTH);
	localparam int unsigned QCNT_W = $clog2(PAIR_DEPTH + 1);

	pair_t              mem_q [PAIR_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               half_q;
	logic               pop, pop_pair;
	pair_t              head;

	// head result selection
	always_comb begin
		head      = mem_q[rd_ptr_q];
		out_res   = half_q ? head.res_b : head.res_a;
		out_valid = (count_q != '0);
		full      = (count_q == QCNT_W'(PAIR_DEPTH));
		pop       = out_valid && !out_stall;
		pop_pair  = pop && half_q;
	end

	// pair storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_pair;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
			half_q   <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= PTR_W'(wr_ptr_q + 1'b1);
			end
			if (pop_pair) begin
				rd_ptr_q <= PTR_W'(rd_ptr_q + 1'b1);
			end
			if (pop) begin
				half_q <= !half_q;
			end
			if (push && !pop_pair) begin
				count_q <= QCNT_W'(count_q + 1'b1);
			end else if (!push && pop_pair) begin
				count_q <= QCNT_W'(count_q - 1'b1);
			end
		end
	end

	// no push into a full queue
	`AVPES_ASSERT_NOW(a_no_overflow, push, !full)
	// fill count stays within the depth
	`AVPES_ASSERT_NOW(a_count_bound, 1'b1, count_q <= QCNT_W'(PAIR_DEPTH))
	// the second half of a pair is only pending while a pair is stored
	`AVPES_ASSERT_NOW(a_half_held, half_q, count_q != '0)

endmodule
